[hdl/wpsp_pkg.sv]
package wpsp_pkg;

  localparam int MAX_CHUNKS_DEFAULT = 32;
  localparam int CHUNK_W = 6;
  localparam int RATE_W = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd16000;

  // Four-character codes, first file byte in the top byte.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_PCM_MONO = 32'h0001_0001;
  localparam logic [15:0] FMT_BITS_16 = 16'd16;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_RIFF = 8'b0000_0010,
    PH_HDR  = 8'b0000_0100,
    PH_FMT  = 8'b0000_1000,
    PH_SKIP = 8'b0001_0000,
    PH_PAD  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_CANCEL = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       cancel_request;
  } in_item_t;

  typedef struct packed {
    logic               frame_valid;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic               done_res;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    phase_t             phase;
    logic [4:0]         byte_position;
    logic [3:0]         id_match_flags;
    logic [31:0]        chunk_length;
    logic [31:0]        skip_remaining;
    logic [CHUNK_W-1:0] chunk_count;
    logic               fmt_valid;
    logic [31:0]        field_accumulator;
    logic [31:0]        data_remaining;
    logic [7:0]         low_sample_byte;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:             PH_IDLE,
    byte_position:     5'd0,
    id_match_flags:    4'hF,
    chunk_length:      32'd0,
    skip_remaining:    32'd0,
    chunk_count:       '0,
    fmt_valid:         1'b0,
    field_accumulator: 32'd0,
    data_remaining:    32'd0,
    low_sample_byte:   8'd0
  };

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = tag[31:24];
      2'd1: r = tag[23:16];
      2'd2: r = tag[15:8];
      default: r = tag[7:0];
    endcase
    return r;
  endfunction

endpackage

[hdl/wpsp_step.sv]
module wpsp_step
  import wpsp_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
  input  parse_state_t      state,
  input  in_item_t          item,
  input  logic [RATE_W-1:0] expected_rate,
  output parse_state_t      state_next,
  output out_item_t         result,
  output logic              result_present
);

  localparam logic [CHUNK_W-1:0] CHUNK_LIMIT = CHUNK_W'(MAX_CHUNKS);

  always_comb begin
    parse_state_t       s;
    logic               active;
    logic               has_end;
    status_t            end_code;
    logic               frame;
    logic [31:0]        value;
    logic [4:0]         pos;
    logic [4:0]         pos_inc;
    logic [7:0]         b;
    logic               do_skip;
    logic               do_close;
    logic [31:0]        skip_n;
    logic [31:0]        acc;
    logic [CHUNK_W-1:0] cnt_inc;

    s = state;
    has_end = 1'b0;
    end_code = ST_OK;
    frame = 1'b0;
    value = 32'd0;
    do_skip = 1'b0;
    do_close = 1'b0;
    skip_n = 32'd0;
    cnt_inc = '0;
    b = item.data_byte;

    if (item.first_byte) begin
      s = STATE_RESET;
      s.phase = PH_RIFF;
    end
    active = (s.phase != PH_IDLE) && (s.phase != PH_DONE);
    pos = s.byte_position;
    pos_inc = pos + 5'd1;
    acc = s.field_accumulator;

    if (active) begin
      if (item.cancel_request) begin
        has_end = 1'b1;
        end_code = ST_CANCEL;
      end else begin
        case (s.phase)
          PH_RIFF: begin
            if (pos < 5'd4 && b != tag_byte(TAG_RIFF, pos[1:0])) begin
              s.id_match_flags[2] = 1'b0;
            end
            if (pos[4:2] == 3'd2 && b != tag_byte(TAG_WAVE, pos[1:0])) begin
              s.id_match_flags[3] = 1'b0;
            end
            s.byte_position = pos_inc;
            if (pos_inc >= 5'd12) begin
              if (s.id_match_flags[3:2] != 2'b11) begin
                has_end = 1'b1;
                end_code = ST_FORMAT;
              end else begin
                s.phase = PH_HDR;
                s.byte_position = 5'd0;
                s.id_match_flags = 4'hF;
                s.chunk_length = 32'd0;
                s.field_accumulator = 32'd0;
              end
            end
          end
          PH_HDR: begin
            if (pos < 5'd4) begin
              if (b != tag_byte(TAG_FMT, pos[1:0])) begin
                s.id_match_flags[0] = 1'b0;
              end
              if (b != tag_byte(TAG_DATA, pos[1:0])) begin
                s.id_match_flags[1] = 1'b0;
              end
            end else if (pos < 5'd8) begin
              s.chunk_length = s.chunk_length | ({24'd0, b} << {pos[1:0], 3'b000});
            end
            s.byte_position = pos_inc;
            if (pos_inc >= 5'd8) begin
              s.byte_position = 5'd0;
              if (s.id_match_flags[0]) begin
                if (s.chunk_length < FMT_MIN_LEN) begin
                  has_end = 1'b1;
                  end_code = ST_FORMAT;
                end else begin
                  s.phase = PH_FMT;
                  s.field_accumulator = 32'd0;
                end
              end else if (s.id_match_flags[1]) begin
                if (!s.fmt_valid || s.chunk_length == 32'd0 || s.chunk_length[0]) begin
                  has_end = 1'b1;
                  end_code = ST_FORMAT;
                end else begin
                  s.data_remaining = s.chunk_length;
                  s.phase = PH_DATA;
                end
              end else begin
                do_skip = 1'b1;
                skip_n = s.chunk_length;
              end
            end
          end
          PH_FMT: begin
            if (pos[1:0] == 2'd0) begin
              acc = {24'd0, b};
            end else begin
              acc = acc | ({24'd0, b} << {pos[1:0], 3'b000});
            end
            s.field_accumulator = acc;
            if (pos == 5'd3 && acc != FMT_PCM_MONO) begin
              s.id_match_flags[0] = 1'b0;
            end
            if (pos == 5'd7 && acc != {{(32-RATE_W){1'b0}}, expected_rate}) begin
              s.id_match_flags[0] = 1'b0;
            end
            if (pos == 5'd15 && acc[31:16] != FMT_BITS_16) begin
              s.id_match_flags[0] = 1'b0;
            end
            s.byte_position = pos_inc;
            if (pos_inc >= 5'd16) begin
              s.byte_position = 5'd0;
              if (!s.id_match_flags[0]) begin
                has_end = 1'b1;
                end_code = ST_FORMAT;
              end else begin
                s.fmt_valid = 1'b1;
                do_skip = 1'b1;
                skip_n = s.chunk_length - FMT_MIN_LEN;
              end
            end
          end
          PH_SKIP: begin
            s.skip_remaining = s.skip_remaining - 32'd1;
            if (s.skip_remaining == 32'd0) begin
              if (s.chunk_length[0]) begin
                s.phase = PH_PAD;
              end else begin
                do_close = 1'b1;
              end
            end
          end
          PH_PAD: begin
            do_close = 1'b1;
          end
          PH_DATA: begin
            if (!s.byte_position[0]) begin
              s.low_sample_byte = b;
              s.byte_position = 5'd1;
            end else begin
              frame = 1'b1;
              value = {b, s.low_sample_byte, 16'h0000};
              s.byte_position = 5'd0;
            end
            s.data_remaining = s.data_remaining - 32'd1;
            if (s.data_remaining == 32'd0) begin
              has_end = 1'b1;
              end_code = ST_OK;
            end
          end
          default: begin
          end
        endcase

        if (do_skip) begin
          s.skip_remaining = skip_n;
          if (skip_n != 32'd0) begin
            s.phase = PH_SKIP;
          end else if (s.chunk_length[0]) begin
            s.phase = PH_PAD;
          end else begin
            do_close = 1'b1;
          end
        end

        // A non-data chunk has been passed; either open the next header or give up.
        cnt_inc = s.chunk_count + 1'b1;
        if (do_close) begin
          s.chunk_count = cnt_inc;
          if (cnt_inc >= CHUNK_LIMIT) begin
            has_end = 1'b1;
            end_code = ST_FORMAT;
          end else begin
            s.phase = PH_HDR;
            s.byte_position = 5'd0;
            s.id_match_flags = 4'hF;
            s.chunk_length = 32'd0;
            s.field_accumulator = 32'd0;
          end
        end
      end

      if (!has_end && item.last_byte) begin
        has_end = 1'b1;
        end_code = ST_TRUNC;
      end
      if (has_end) begin
        s.phase = PH_DONE;
      end
    end

    state_next = s;
    result_present = active && (frame || has_end);
    result.frame_valid = frame;
    result.left_sample = $signed(value);
    result.right_sample = $signed(value);
    result.done_res = has_end;
    result.status = has_end ? end_code : ST_OK;
  end

endmodule

[hdl/wav_pcm_stream_parser.sv]
// Byte-wide WAV parser: one file byte is taken per clock cycle while in_ready is high,
// and its stereo frame or end status appears in the output register on the following
// cycle. in_ready is low only while that output register holds a result the sink has
// not taken yet, so with a free sink the block runs at one byte per cycle. The sample
// rate register may be written at any time on the cfg channel, which is always ready.
module wav_pcm_stream_parser
  import wpsp_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data
);

  parse_state_t      state;
  parse_state_t      state_next;
  out_item_t         result;
  logic              result_present;
  logic [RATE_W-1:0] expected_rate;
  logic              in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_xfer = in_valid && in_ready;

  wpsp_step #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_step (
    .state         (state),
    .item          (in_item),
    .expected_rate (expected_rate),
    .state_next    (state_next),
    .result        (result),
    .result_present(result_present)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state <= state_next;
      end
      if (in_xfer && result_present) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && result_present) begin
      out_item <= result;
    end
  end

`ifndef ASSERT_OFF
  // A done result always leaves the parser parked until the next first byte.
  a_done_parks: assert property (@(posedge clk) disable iff (rst)
    in_xfer && result_present && result.done_res |=> state.phase == PH_DONE)
    else $error("done result did not park the parser");

  // Every result carries a frame or an end status, and a frame has equal channels.
  a_result_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.frame_valid || out_item.done_res) &&
                  out_item.left_sample == out_item.right_sample)
    else $error("malformed result");

  // Without a first byte, an idle or finished parser ignores its input.
  a_idle_ignores: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !in_item.first_byte && (state.phase == PH_IDLE || state.phase == PH_DONE)
    |-> !result_present && state_next == state)
    else $error("idle parser reacted to a byte");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.done_res |-> out_item.status == ST_OK)
    else $error("status set without done");
`endif

endmodule
